FILE: hw/rtl/tcgr_pkg.sv
// Shared types, constants and register codes for the text console glyph renderer.
package tcgr_pkg;

   localparam int SCREEN_WIDTH_DEFAULT  = 320;
   localparam int SCREEN_HEIGHT_DEFAULT = 200;

   localparam int FONT_DEPTH = 2048;
   localparam int FONT_AW    = 11;

   localparam logic [9:0] CURSOR_X_MAX = 10'd1023;
   localparam logic [9:0] CURSOR_Y_MAX = 10'd1016;

   // character codes with cursor meaning
   localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
   localparam logic [7:0] CHAR_TAB       = 8'd9;
   localparam logic [7:0] CHAR_NEWLINE   = 8'd10;

   localparam logic OP_RENDER     = 1'b0;
   localparam logic OP_FONT_WRITE = 1'b1;

   // configuration register indexes
   localparam logic [2:0] CSR_WINDOW_LEFT      = 3'd0;
   localparam logic [2:0] CSR_WINDOW_TOP       = 3'd1;
   localparam logic [2:0] CSR_WINDOW_RIGHT     = 3'd2;
   localparam logic [2:0] CSR_WINDOW_BOTTOM    = 3'd3;
   localparam logic [2:0] CSR_BACKGROUND_COLOR = 3'd4;

   localparam logic [8:0] WINDOW_LEFT_RESET      = 9'd50;
   localparam logic [7:0] WINDOW_TOP_RESET       = 8'd50;
   localparam logic [8:0] WINDOW_RIGHT_RESET     = 9'd270;
   localparam logic [7:0] WINDOW_BOTTOM_RESET    = 8'd150;
   localparam logic [7:0] BACKGROUND_COLOR_RESET = 8'd0;

   typedef struct packed {
      logic                op;
      logic [7:0]          char_code;
      logic [7:0]          fg_color;
      logic [FONT_AW-1:0]  font_address;
      logic [7:0]          font_byte;
   } req_type;

   typedef struct packed {
      logic [15:0] pixel_address;
      logic [7:0]  pixel_color;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [8:0] left;
      logic [7:0] top;
      logic [8:0] right;
      logic [7:0] bottom;
   } window_type;

   // what one cursor step decided
   typedef struct packed {
      logic       again;  // tab needs its second cell
      logic       draw;   // a cell scan follows
      logic       paint;  // scan paints background instead of glyph bits
      logic [9:0] org_x;
      logic [9:0] org_y;
   } plan_type;

endpackage

FILE: hw/rtl/tcgr_cursor.sv
// Cursor registers and the per-character cursor step (wrap, tab, newline, backspace).
module tcgr_cursor #(
   parameter int SCREEN_WIDTH = tcgr_pkg::SCREEN_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tcgr_pkg::window_type  win,
   input  logic                  move_en,
   input  logic [7:0]            char_code,
   output tcgr_pkg::plan_type    plan
);

   logic [9:0] cursor_x_ff, cursor_x_in;
   logic [9:0] cursor_y_ff, cursor_y_in;
   logic       tab_phase_ff, tab_phase_in;

   logic [10:0] x_plus;
   logic [10:0] y_plus;
   logic        wrap_need;
   logic [9:0]  y_down;
   logic [9:0]  wrap_x, wrap_y;
   logic [10:0] wrap_x_plus, wrap_y_plus;
   logic [9:0]  adv_x;
   logic        in_window;
   logic        at_left;
   logic signed [12:0] span, span_al, bs_x;
   logic [9:0]  bs_x_c, bs_y_c;
   logic [9:0]  bs_new_x, bs_new_y;

   always_comb begin
      x_plus    = {1'b0, cursor_x_ff} + 11'd8;
      y_plus    = {1'b0, cursor_y_ff} + 11'd8;
      y_down    = (cursor_y_ff < 10'd8) ? 10'd0 : cursor_y_ff - 10'd8;
      wrap_need = x_plus > {2'b0, win.right};
      wrap_x    = wrap_need ? {1'b0, win.left} : cursor_x_ff;
      if (!wrap_need)
         wrap_y = cursor_y_ff;
      else if (y_plus > {1'b0, tcgr_pkg::CURSOR_Y_MAX})
         wrap_y = tcgr_pkg::CURSOR_Y_MAX;
      else
         wrap_y = y_plus[9:0];
      wrap_x_plus = {1'b0, wrap_x} + 11'd8;
      wrap_y_plus = {1'b0, wrap_y} + 11'd8;
      adv_x = (wrap_x_plus > {1'b0, tcgr_pkg::CURSOR_X_MAX}) ? tcgr_pkg::CURSOR_X_MAX
                                                           : wrap_x_plus[9:0];
      in_window = (wrap_x >= {1'b0, win.left}) && (wrap_x_plus <= {2'b0, win.right}) &&
                  (wrap_y >= {2'b0, win.top}) && (wrap_y_plus <= {3'b0, win.bottom});

      // backspace: step back, wrap to the end of the previous row, or stay put on the top row
      at_left = {1'b0, cursor_x_ff} < ({2'b0, win.left} + 11'd8);
      span    = 13'(SCREEN_WIDTH) - {3'b0, win.left, 1'b0};
      span_al = (span < 0) ? 13'sd0 : (span & ~13'sd7);
      bs_x    = span_al + {4'b0, win.left} - 13'sd8;
      if (bs_x < 0)
         bs_x_c = 10'd0;
      else if (bs_x > 13'sd1023)
         bs_x_c = tcgr_pkg::CURSOR_X_MAX;
      else
         bs_x_c = bs_x[9:0];
      bs_y_c = y_down;
      if (!at_left) begin
         bs_new_x = cursor_x_ff - 10'd8;
         bs_new_y = cursor_y_ff;
      end else if (cursor_y_ff != {2'b0, win.top}) begin
         bs_new_x = bs_x_c;
         bs_new_y = bs_y_c;
      end else begin
         bs_new_x = cursor_x_ff;
         bs_new_y = cursor_y_ff;
      end
   end

   always_comb begin
      cursor_x_in  = cursor_x_ff;
      cursor_y_in  = cursor_y_ff;
      tab_phase_in = tab_phase_ff;
      plan         = '0;
      case (char_code)
         tcgr_pkg::CHAR_NEWLINE: begin
            cursor_x_in = {1'b0, win.left};
            cursor_y_in = (y_plus > {1'b0, tcgr_pkg::CURSOR_Y_MAX}) ?
                          tcgr_pkg::CURSOR_Y_MAX : y_plus[9:0];
         end
         tcgr_pkg::CHAR_TAB: begin
            cursor_x_in  = adv_x;
            cursor_y_in  = wrap_y;
            tab_phase_in = !tab_phase_ff;
            plan.again   = !tab_phase_ff;
         end
         tcgr_pkg::CHAR_BACKSPACE: begin
            cursor_x_in = bs_new_x;
            cursor_y_in = bs_new_y;
            plan.draw   = 1'b1;
            plan.paint  = 1'b1;
            plan.org_x  = bs_new_x;
            plan.org_y  = bs_new_y;
         end
         default: begin
            cursor_x_in = adv_x;
            cursor_y_in = wrap_y;
            plan.draw   = in_window;
            plan.org_x  = wrap_x;
            plan.org_y  = wrap_y;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff  <= {1'b0, tcgr_pkg::WINDOW_LEFT_RESET};
         cursor_y_ff  <= {2'b0, tcgr_pkg::WINDOW_TOP_RESET};
         tab_phase_ff <= 1'b0;
      end else if (move_en) begin
         cursor_x_ff  <= cursor_x_in;
         cursor_y_ff  <= cursor_y_in;
         tab_phase_ff <= tab_phase_in;
      end
   end

endmodule

FILE: hw/rtl/text_console_glyph_renderer.sv
// Top level: font store, configuration registers and the cell pixel scanner.
//
// Text console renderer for 8x8 character cells. Newline and tab make no pixel
// writes. A printable character inside the window, and any backspace, passes
// through accept, the cursor step, a fetch of the first glyph row, the pixel scan
// and a flush of the final write; the scan waits when a result stall leaves no
// room for a new write. The scan walks the cell one pixel position per cycle while
// it is not held that way, through the font store's one read port, so it visits
// every position whether the cell sets few or many pixels. The block takes no new
// item until the final write of the current one has moved into the output register.
module text_console_glyph_renderer #(
   parameter int SCREEN_WIDTH  = tcgr_pkg::SCREEN_WIDTH_DEFAULT,
   parameter int SCREEN_HEIGHT = tcgr_pkg::SCREEN_HEIGHT_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tcgr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tcgr_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [8:0]        csr_data
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MOVE  = 3'd1;
   localparam logic [2:0] S_FETCH = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_FLUSH = 3'd4;

   localparam logic [10:0] SW = 11'(SCREEN_WIDTH);
   localparam logic [10:0] SH = 11'(SCREEN_HEIGHT);

   logic [2:0] state_ff, state_in;

   tcgr_pkg::window_type win_ff;
   logic [7:0]           bg_ff;

   logic [7:0] code_ff;
   logic [7:0] fg_ff;
   logic       paint_ff;
   logic [9:0] org_x_ff, org_y_ff;
   logic [2:0] row_ff, col_ff;
   logic [15:0] row_base_ff;

   logic [7:0] font_mem [tcgr_pkg::FONT_DEPTH];
   logic [7:0] font_q;
   logic       rd_en;
   logic [2:0] rd_row;
   logic [tcgr_pkg::FONT_AW-1:0] rd_addr;

   logic        hold_valid_ff;
   logic [15:0] hold_addr_ff;
   logic [7:0]  hold_color_ff;

   logic              rsp_valid_ff;
   tcgr_pkg::rsp_type rsp_data_ff;

   tcgr_pkg::plan_type plan;
   logic               accept;
   logic               move_en;

   logic [10:0] px, py;
   logic        pix_on, cand, out_free, step;
   logic        push_hold, flush_push;
   logic [20:0] base_prod;
   logic [15:0] pix_addr;
   logic [7:0]  pix_color;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign move_en   = (state_ff == S_MOVE);

   tcgr_cursor #(
      .SCREEN_WIDTH (SCREEN_WIDTH)
   ) u_cursor (
      .clock     (clock),
      .reset     (reset),
      .win       (win_ff),
      .move_en   (move_en),
      .char_code (code_ff),
      .plan      (plan)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff.left   <= tcgr_pkg::WINDOW_LEFT_RESET;
         win_ff.top    <= tcgr_pkg::WINDOW_TOP_RESET;
         win_ff.right  <= tcgr_pkg::WINDOW_RIGHT_RESET;
         win_ff.bottom <= tcgr_pkg::WINDOW_BOTTOM_RESET;
         bg_ff         <= tcgr_pkg::BACKGROUND_COLOR_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tcgr_pkg::CSR_WINDOW_LEFT:      win_ff.left   <= csr_data;
            tcgr_pkg::CSR_WINDOW_TOP:       win_ff.top    <= csr_data[7:0];
            tcgr_pkg::CSR_WINDOW_RIGHT:     win_ff.right  <= csr_data;
            tcgr_pkg::CSR_WINDOW_BOTTOM:    win_ff.bottom <= csr_data[7:0];
            tcgr_pkg::CSR_BACKGROUND_COLOR: bg_ff         <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // font store; the next row is prefetched on the last column of a row
   assign rd_row  = (state_ff == S_FETCH) ? 3'd0 : row_ff + 3'd1;
   assign rd_addr = {code_ff, rd_row};
   assign rd_en   = (state_ff == S_FETCH) || ((state_ff == S_SCAN) && step && (col_ff == 3'd7));

   always_ff @(posedge clock) begin
      if (accept && (req_data.op == tcgr_pkg::OP_FONT_WRITE))
         font_mem[req_data.font_address] <= req_data.font_byte;
      if (rd_en)
         font_q <= font_mem[rd_addr];
   end

   // pixel candidate at the current scan position
   always_comb begin
      px        = {1'b0, org_x_ff} + {8'b0, col_ff};
      py        = {1'b0, org_y_ff} + {8'b0, row_ff};
      pix_on    = paint_ff || font_q[3'd7 - col_ff];
      cand      = pix_on && (px < SW) && (py < SH);
      pix_addr  = row_base_ff + {6'b0, org_x_ff} + {13'b0, col_ff};
      pix_color = paint_ff ? bg_ff : fg_ff;
      base_prod = {11'b0, org_y_ff} * {10'b0, SW};
      out_free  = !rsp_valid_ff || rsp_ready;
      // a new candidate can only displace the held write if the output slot is free
      step       = !(cand && hold_valid_ff && !out_free);
      push_hold  = (state_ff == S_SCAN) && step && cand && hold_valid_ff;
      flush_push = (state_ff == S_FLUSH) && hold_valid_ff && out_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (accept && (req_data.op == tcgr_pkg::OP_RENDER)) state_in = S_MOVE;
         S_MOVE: begin
            if (plan.again)
               state_in = S_MOVE;
            else if (plan.draw)
               state_in = S_FETCH;
            else
               state_in = S_IDLE;
         end
         S_FETCH: state_in = S_SCAN;
         S_SCAN:  if (step && (row_ff == 3'd7) && (col_ff == 3'd7)) state_in = S_FLUSH;
         S_FLUSH: if (!hold_valid_ff || flush_push) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if ((state_ff == S_SCAN) && step && cand)
            hold_valid_ff <= 1'b1;
         else if (flush_push)
            hold_valid_ff <= 1'b0;
         if (push_hold || flush_push)
            rsp_valid_ff <= 1'b1;
         else if (rsp_ready)
            rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         code_ff <= req_data.char_code;
         fg_ff   <= req_data.fg_color;
      end
      if (move_en) begin
         org_x_ff <= plan.org_x;
         org_y_ff <= plan.org_y;
         paint_ff <= plan.paint;
      end
      if (state_ff == S_FETCH) begin
         row_ff      <= 3'd0;
         col_ff      <= 3'd0;
         row_base_ff <= base_prod[15:0];
      end else if ((state_ff == S_SCAN) && step) begin
         col_ff <= col_ff + 3'd1;
         if (col_ff == 3'd7) begin
            row_ff      <= row_ff + 3'd1;
            row_base_ff <= row_base_ff + {5'b0, SW};
         end
      end
      if ((state_ff == S_SCAN) && step && cand) begin
         hold_addr_ff  <= pix_addr;
         hold_color_ff <= pix_color;
      end
      if (push_hold || flush_push) begin
         rsp_data_ff.pixel_address <= hold_addr_ff;
         rsp_data_ff.pixel_color   <= hold_color_ff;
         rsp_data_ff.last          <= flush_push;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: hw/rtl/tcgr_checker.sv
// Port-level assertions for the glyph renderer, bound to the top level.
module tcgr_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input tcgr_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input tcgr_pkg::rsp_type rsp_data
);

   // a stalled result transfer keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // a render item always occupies the block for at least the cursor step
   a_render_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.op == tcgr_pkg::OP_RENDER) |=> !req_ready)
      else $error("ready right after render transfer");

   // a font write does not hold the block
   a_font_quick: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.op == tcgr_pkg::OP_FONT_WRITE) |=> req_ready)
      else $error("font write held the block");

   // a write that is not the final one means the item is still in progress
   a_not_last_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> !req_ready)
      else $error("input taken before the final write of an item");

endmodule

bind text_console_glyph_renderer tcgr_checker u_tcgr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

FILE: tb/sv/tcgr_pixel_checker.sv
// Scoreboard for the glyph renderer: mirrors cursor, window and font store, checks pixel writes.
module tcgr_pixel_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  tcgr_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  tcgr_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [8:0]        csr_data,
   output int                mismatch_count,
   output int                pending_results
);
   import tcgr_pkg::*;

   localparam int CELL         = 8;
   localparam int SCR_W        = SCREEN_WIDTH_DEFAULT;
   localparam int SCR_H        = SCREEN_HEIGHT_DEFAULT;
   localparam int X_MAX        = int'(CURSOR_X_MAX);
   localparam int Y_MAX        = int'(CURSOR_Y_MAX);
   localparam int REPORT_LIMIT = 10;

   int         cur_x;
   int         cur_y;
   logic [8:0] win_left;
   logic [7:0] win_top;
   logic [8:0] win_right;
   logic [7:0] win_bottom;
   logic [7:0] bg_color;
   logic [7:0] font_rom [FONT_DEPTH];

   rsp_type    expected_writes [$];
   rsp_type    want;
   logic [7:0] row_bits;
   int         errors = 0;
   int         n_before;
   int         span;
   int         row;
   int         col;

   function automatic int clamp_to(input int v, input int hi);
      if (v < 0)
         return 0;
      if (v > hi)
         return hi;
      return v;
   endfunction

   task automatic plot(input int x, input int y, input logic [7:0] color);
      rsp_type w;
      if (x >= 0 && x < SCR_W && y >= 0 && y < SCR_H) begin
         w.pixel_address = 16'(y * SCR_W + x);
         w.pixel_color   = color;
         w.last          = 1'b0;
         expected_writes.push_back(w);
      end
   endtask

   // a cell that would cross the right bound starts on the next row
   task automatic next_row_if_full();
      if (cur_x + CELL > int'(win_right)) begin
         cur_y = clamp_to(cur_y + CELL, Y_MAX);
         cur_x = int'(win_left);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         win_left   = WINDOW_LEFT_RESET;
         win_top    = WINDOW_TOP_RESET;
         win_right  = WINDOW_RIGHT_RESET;
         win_bottom = WINDOW_BOTTOM_RESET;
         bg_color   = BACKGROUND_COLOR_RESET;
         cur_x      = int'(WINDOW_LEFT_RESET);
         cur_y      = int'(WINDOW_TOP_RESET);
         expected_writes.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_writes.size() == 0) begin
               if (errors < REPORT_LIMIT)
                  $display("unexpected pixel write: address %0d color %0d last %0b",
                           rsp_data.pixel_address, rsp_data.pixel_color, rsp_data.last);
               errors++;
            end else begin
               want = expected_writes.pop_front();
               if (rsp_data.pixel_address !== want.pixel_address ||
                   rsp_data.pixel_color !== want.pixel_color ||
                   rsp_data.last !== want.last) begin
                  if (errors < REPORT_LIMIT)
                     $display({"pixel write mismatch: expected address %0d color %0d last %0b,",
                               " got address %0d color %0d last %0b"},
                              want.pixel_address, want.pixel_color, want.last,
                              rsp_data.pixel_address, rsp_data.pixel_color, rsp_data.last);
                  errors++;
               end
            end
         end

         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WINDOW_LEFT:      win_left   = csr_data;
               CSR_WINDOW_TOP:       win_top    = csr_data[7:0];
               CSR_WINDOW_RIGHT:     win_right  = csr_data;
               CSR_WINDOW_BOTTOM:    win_bottom = csr_data[7:0];
               CSR_BACKGROUND_COLOR: bg_color   = csr_data[7:0];
               default: ;
            endcase
         end

         if (req_valid && req_ready) begin
            if (req_data.op == OP_FONT_WRITE) begin
               font_rom[req_data.font_address] = req_data.font_byte;
            end else begin
               n_before = expected_writes.size();
               case (req_data.char_code)
                  CHAR_NEWLINE: begin
                     cur_y = clamp_to(cur_y + CELL, Y_MAX);
                     cur_x = int'(win_left);
                  end
                  CHAR_TAB: begin
                     repeat (2) begin
                        next_row_if_full();
                        cur_x = clamp_to(cur_x + CELL, X_MAX);
                     end
                  end
                  CHAR_BACKSPACE: begin
                     if (cur_x - CELL < int'(win_left)) begin
                        // wrap to the last cell of the previous row, unless on the top row
                        if (cur_y != int'(win_top)) begin
                           span = SCR_W - 2 * int'(win_left);
                           if (span < 0)
                              span = 0;
                           cur_y = clamp_to(cur_y - CELL, Y_MAX);
                           cur_x = clamp_to((span / CELL) * CELL + int'(win_left) - CELL, X_MAX);
                        end
                     end else begin
                        cur_x = clamp_to(cur_x - CELL, X_MAX);
                     end
                     for (row = 0; row < CELL; row++)
                        for (col = 0; col < CELL; col++)
                           plot(cur_x + col, cur_y + row, bg_color);
                  end
                  default: begin
                     next_row_if_full();
                     if (cur_x >= int'(win_left) && cur_x + CELL <= int'(win_right) &&
                         cur_y >= int'(win_top) && cur_y + CELL <= int'(win_bottom)) begin
                        for (row = 0; row < CELL; row++) begin
                           row_bits = font_rom[{req_data.char_code, 3'(row)}];
                           for (col = 0; col < CELL; col++)
                              if (row_bits[7 - col])
                                 plot(cur_x + col, cur_y + row, req_data.fg_color);
                        end
                     end
                     cur_x = clamp_to(cur_x + CELL, X_MAX);
                  end
               endcase
               if (expected_writes.size() > n_before) begin
                  want = expected_writes.pop_back();
                  want.last = 1'b1;
                  expected_writes.push_back(want);
               end
            end
         end
      end
      mismatch_count  <= errors;
      pending_results <= expected_writes.size();
   end

endmodule

FILE: tb/sv/tb_top.sv
// Testbench top: clock, reset, character and register stimulus, and the final verdict.
module tb_top;
   import tcgr_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 100;
   localparam int PHASE_ITEMS    = 16;

   typedef enum logic [1:0] {
      RX_ALWAYS,
      RX_COIN,
      RX_PERIODIC,
      RX_SPARSE
   } rx_pattern_t;

   logic        clock;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [8:0]  csr_data  = '0;

   int          mismatch_count;
   int          pending_results;
   int          quiet_cycles = 0;
   int          burst_left   = 0;
   rx_pattern_t rx_pattern   = RX_ALWAYS;
   int          pattern_left = 0;
   logic [7:0]  rx_tick      = '0;
   logic [7:0]  glyph_codes [$];

   text_console_glyph_renderer uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   tcgr_pixel_checker pixel_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // pixel sink: switches at random between stall patterns
   always @(posedge clock) begin
      if (pattern_left == 0) begin
         rx_pattern   <= rx_pattern_t'($urandom_range(0, 3));
         pattern_left <= $urandom_range(40, 400);
      end else begin
         pattern_left <= pattern_left - 1;
      end
      rx_tick <= rx_tick + 8'd1;
      case (rx_pattern)
         RX_ALWAYS:   rsp_ready <= 1'b1;
         RX_COIN:     rsp_ready <= 1'($urandom_range(0, 1));
         RX_PERIODIC: rsp_ready <= (rx_tick[1:0] == 2'b00);
         default:     rsp_ready <= ($urandom_range(0, 9) == 0);
      endcase
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_type render_item(input logic [7:0] code, input logic [7:0] fg);
      req_type item;
      item.op           = OP_RENDER;
      item.char_code    = code;
      item.fg_color     = fg;
      item.font_address = 11'($urandom);
      item.font_byte    = 8'($urandom);
      return item;
   endfunction

   function automatic req_type font_item(input logic [FONT_AW-1:0] addr, input logic [7:0] bits);
      req_type item;
      item.op           = OP_FONT_WRITE;
      item.char_code    = 8'($urandom);
      item.fg_color     = 8'($urandom);
      item.font_address = addr;
      item.font_byte    = bits;
      return item;
   endfunction

   // valid stays high across a burst and drops in the gaps between bursts
   task automatic send_item(input req_type item);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // rows[63:56] is the top row of the glyph
   task automatic load_glyph(input logic [7:0] code, input logic [63:0] rows);
      for (int r = 0; r < 8; r++)
         send_item(font_item({code, 3'(r)}, rows[63 - 8 * r -: 8]));
      if (code != CHAR_BACKSPACE && code != CHAR_TAB && code != CHAR_NEWLINE)
         glyph_codes.push_back(code);
   endtask

   task automatic put_reg(input logic [2:0] index, input logic [8:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic configure(input window_type win, input logic [7:0] bg);
      put_reg(CSR_WINDOW_LEFT, win.left);
      put_reg(CSR_WINDOW_TOP, {1'b0, win.top});
      put_reg(CSR_WINDOW_RIGHT, win.right);
      put_reg(CSR_WINDOW_BOTTOM, {1'b0, win.bottom});
      // unmapped index, must be dropped
      put_reg(CSR_BACKGROUND_COLOR + 3'($urandom_range(1, 3)), 9'($urandom));
      put_reg(CSR_BACKGROUND_COLOR, {1'b0, bg});
      csr_valid <= 1'b0;
   endtask

   // drain all pixel writes, then give a silent item time to finish
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input window_type win, input logic [7:0] bg, input int climb,
                            input int count);
      int pick;
      settle();
      configure(win, bg);
      repeat (climb) send_item(render_item(CHAR_BACKSPACE, 8'($urandom)));
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 5)
            load_glyph(8'($urandom), {$urandom, $urandom});
         else if (pick < 12)
            send_item(font_item(11'($urandom), 8'($urandom)));
         else if (pick < 18)
            send_item(render_item(CHAR_NEWLINE, 8'($urandom)));
         else if (pick < 25)
            send_item(render_item(CHAR_TAB, 8'($urandom)));
         else if (pick < 40)
            send_item(render_item(CHAR_BACKSPACE, 8'($urandom)));
         else
            send_item(render_item(glyph_codes[$urandom_range(0, glyph_codes.size() - 1)],
                                  8'($urandom)));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // solid glyph at code 0 gives a full 64-pixel cell
      load_glyph(8'h00, {8{8'hFF}});
      load_glyph(8'hFF, 64'h007E_8155_AA3C_0180);
      // home position on the top row: cursor stays, cell is erased
      send_item(render_item(CHAR_BACKSPACE, 8'h00));
      send_item(render_item(8'h00, 8'hFF));
      send_item(render_item(8'hFF, 8'h00));
      send_item(render_item(CHAR_TAB, 8'h5A));
      send_item(render_item(CHAR_NEWLINE, 8'hA5));
      // at the left edge below the top row: back up to the end of the row above
      send_item(render_item(CHAR_BACKSPACE, 8'h33));
      send_item(render_item(CHAR_BACKSPACE, 8'hCC));
      send_item(render_item(8'h00, 8'h81));

      run_phase(window_type'{left: 9'd50, top: 8'd50, right: 9'd270, bottom: 8'd150},
                8'($urandom), 0, PHASE_ITEMS);
      run_phase(window_type'{left: 9'd0, top: 8'd0, right: 9'd320, bottom: 8'd200},
                8'hFF, 0, PHASE_ITEMS);
      // left past mid-screen: each backspace climbs a row, down to row zero
      run_phase(window_type'{left: 9'd200, top: 8'd7, right: 9'd320, bottom: 8'd200},
                8'h00, 24, PHASE_ITEMS);
      run_phase(window_type'{left: 9'd8, top: 8'd8, right: 9'd100, bottom: 8'd60},
                8'($urandom), 0, PHASE_ITEMS);
      run_phase(window_type'{left: 9'd319, top: 8'd199, right: 9'd320, bottom: 8'd200},
                8'($urandom), 0, PHASE_ITEMS);
      run_phase(window_type'{left: 9'd100, top: 8'd20, right: 9'd0, bottom: 8'd0},
                8'($urandom), 0, PHASE_ITEMS);
      run_phase(window_type'{left: 9'($urandom_range(0, 319)), top: 8'($urandom_range(0, 199)),
                             right: 9'($urandom_range(0, 320)),
                             bottom: 8'($urandom_range(0, 200))},
                8'($urandom), 0, PHASE_ITEMS);

      // zero-width window: every tab cell wraps, driving cursor y into saturation
      settle();
      configure(window_type'{left: 9'd0, top: 8'd0, right: 9'd0, bottom: 8'd200}, 8'hA5);
      repeat (66) send_item(render_item(CHAR_TAB, 8'($urandom)));
      repeat (2) send_item(render_item(CHAR_NEWLINE, 8'($urandom)));
      send_item(render_item(glyph_codes[0], 8'($urandom)));
      repeat (2) send_item(render_item(CHAR_BACKSPACE, 8'($urandom)));
      settle();

      if (mismatch_count == 0 && pending_results == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
